>>> rtl/five_tuple_rule_matcher_core_defines.svh
// Assertion macros shared by the five-tuple rule matcher RTL.
`ifndef FIVE_TUPLE_RULE_MATCHER_CORE_DEFINES_SVH
`define FIVE_TUPLE_RULE_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FTRM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("five-tuple rule matcher: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FTRM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("five-tuple rule matcher: next-cycle check failed");

`endif

>>> rtl/ftrm_pkg.sv
// Types and constants of the five-tuple rule matcher.
package ftrm_pkg;

  localparam int DEF_PROTOCOL_ENTRIES = 8;
  localparam int DEF_PREFIX_ENTRIES   = 8;
  localparam int DEF_RANGE_ENTRIES    = 8;

  localparam logic [7:0]  DEF_PROTO_A = 8'd6;
  localparam logic [7:0]  DEF_PROTO_B = 8'd17;
  localparam logic [15:0] PORT_MAX    = 16'hFFFF;
  localparam logic [31:0] ADDR_ANY    = 32'h0000_0000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECTION_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RULE_PRIORITY = 1'd1;

  localparam int IN_TDATA_W  = 200;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

  typedef enum logic [2:0] {
    OP_MATCH      = 3'd0,
    OP_ADD_PROTO  = 3'd1,
    OP_ADD_SRC_PF = 3'd2,
    OP_ADD_DST_PF = 3'd3,
    OP_ADD_SRC_RG = 3'd4,
    OP_ADD_DST_RG = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MATCH,
    ST_ADD,
    ST_EMIT
  } state_t;

  // One row of the rule memory: entry i of every list.
  typedef struct packed {
    logic [7:0]  proto;
    logic [31:0] sp_addr;
    logic [31:0] sp_mask;
    logic [31:0] dp_addr;
    logic [31:0] dp_mask;
    logic [15:0] sr_lo;
    logic [15:0] sr_hi;
    logic [15:0] dr_lo;
    logic [15:0] dr_hi;
  } row_t;

endpackage

>>> rtl/five_tuple_rule_matcher_core.sv
// Top level of the five-tuple rule matcher: one classification rule held in a rule memory.
//
// The block holds one rule made of five bounded lists (protocols, source and destination
// address/mask pairs, source and destination port ranges) in a single rule memory whose
// row i carries entry i of every list. Each input word carries one operation in
// in_tuser and gives exactly one result word. A match reads the memory one row per cycle
// through its single read port, all five lists being tested side by side, and walks as
// many rows as the largest of the five list counts. An add reads the row, merges the new
// entry and writes it back; a clear, a refused add and the unused code go straight to the
// output stage. After reset the block writes the default entries into the memory before
// it takes its first word; configuration writes are taken at any time. A finished result
// sits in the output register, and the next word is accepted while it waits to be taken.
module five_tuple_rule_matcher_core #(
  parameter int PROTOCOL_ENTRIES = ftrm_pkg::DEF_PROTOCOL_ENTRIES,
  parameter int PREFIX_ENTRIES   = ftrm_pkg::DEF_PREFIX_ENTRIES,
  parameter int RANGE_ENTRIES    = ftrm_pkg::DEF_RANGE_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // from bit 0: src_address, dst_address, src_port, dst_port, protocol,
  // rule_address, rule_mask, range_low, range_high
  input  logic [ftrm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // from bit 0: operation
  input  logic [ftrm_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // from bit 0: matched, match_connection_id, match_priority, zero fill
  output logic [ftrm_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // from bit 0: status
  output logic [ftrm_pkg::OUT_TUSER_W-1:0]  out_tuser
);

  import ftrm_pkg::*;

  `include "five_tuple_rule_matcher_core_defines.svh"

  // The memory is as deep as the longest list; rows beyond a list's count are never read
  // for that list.
  localparam int ROWS_A = (PROTOCOL_ENTRIES > PREFIX_ENTRIES) ? PROTOCOL_ENTRIES
                                                              : PREFIX_ENTRIES;
  localparam int ROWS   = (ROWS_A > RANGE_ENTRIES) ? ROWS_A : RANGE_ENTRIES;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W  = $clog2(ROWS + 1);
  localparam int ROW_W  = $bits(row_t);
  localparam bit INIT_LAST = (ROWS > 1);

  localparam logic [CNT_W-1:0] PROTO_CAP  = CNT_W'(PROTOCOL_ENTRIES);
  localparam logic [CNT_W-1:0] PREFIX_CAP = CNT_W'(PREFIX_ENTRIES);
  localparam logic [CNT_W-1:0] RANGE_CAP  = CNT_W'(RANGE_ENTRIES);
  localparam logic [CNT_W-1:0] PROTO_RST  = (PROTOCOL_ENTRIES >= 2) ? CNT_W'(2) : CNT_W'(1);
  localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

  // Control state.
  state_t           state_r, state_nxt;
  logic             init_idx_r, init_idx_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0] spcnt_r, spcnt_nxt;
  logic [CNT_W-1:0] dpcnt_r, dpcnt_nxt;
  logic [CNT_W-1:0] srcnt_r, srcnt_nxt;
  logic [CNT_W-1:0] drcnt_r, drcnt_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      conn_id_r;
  logic [7:0]       prio_r;

  // Match walk and per-item working registers.
  logic [CNT_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic [CNT_W-1:0]  pidx_r, pidx_nxt;
  logic [CNT_W-1:0]  span_r, span_nxt;
  logic [ROW_AW-1:0] add_idx_r, add_idx_nxt;
  logic              hp_r, hp_nxt;
  logic              hsp_r, hsp_nxt;
  logic              hdp_r, hdp_nxt;
  logic              hsr_r, hsr_nxt;
  logic              hdr_r, hdr_nxt;
  logic              res_status_r, res_status_nxt;
  logic              res_matched_r, res_matched_nxt;

  // Captured input word.
  op_t         op_r;
  logic [31:0] src_addr_r, dst_addr_r, rule_addr_r, rule_mask_r;
  logic [15:0] src_port_r, dst_port_r, range_lo_r, range_hi_r;
  logic [7:0]  protocol_r;

  // Output register.
  logic        out_status_r, out_matched_r;
  logic [15:0] out_conn_r;
  logic [7:0]  out_prio_r;
  logic        out_load;

  // Rule memory port.
  logic              ram_we, ram_re;
  logic [ROW_AW-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;
  row_t              cur_row;

  logic       in_acc;
  op_t        in_op;
  logic       counts_ok;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser[2:0]);
  assign cur_row   = row_t'(ram_rdata);

  ftrm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_rule_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer. The memory is never written and read in the same cycle: a write happens
  // only in the add state or during the start-up fill, and neither state issues a read,
  // so no forwarding path is needed.
  always_comb begin
    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W-1:0] sel_cap;
    logic [CNT_W-1:0] span_a;
    logic [CNT_W-1:0] span_b;
    logic             issue;
    row_t             init_row;
    row_t             wr_row;

    state_nxt       = state_r;
    init_idx_nxt    = init_idx_r;
    pcnt_nxt        = pcnt_r;
    spcnt_nxt       = spcnt_r;
    dpcnt_nxt       = dpcnt_r;
    srcnt_nxt       = srcnt_r;
    drcnt_nxt       = drcnt_r;
    pend_nxt        = 1'b0;
    iss_idx_nxt     = iss_idx_r;
    pidx_nxt        = pidx_r;
    span_nxt        = span_r;
    add_idx_nxt     = add_idx_r;
    hp_nxt          = hp_r;
    hsp_nxt         = hsp_r;
    hdp_nxt         = hdp_r;
    hsr_nxt         = hsr_r;
    hdr_nxt         = hdr_r;
    res_status_nxt  = res_status_r;
    res_matched_nxt = res_matched_r;
    out_load        = 1'b0;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    ram_waddr       = '0;
    ram_raddr       = '0;
    ram_wdata       = '0;

    // Default entries written after reset: row 0 holds the first protocol, the wildcard
    // prefixes and the full port ranges; row 1 holds the second protocol.
    init_row       = '0;
    init_row.proto = init_idx_r ? DEF_PROTO_B : DEF_PROTO_A;
    init_row.sp_addr = ADDR_ANY;
    init_row.dp_addr = ADDR_ANY;
    init_row.sr_hi = PORT_MAX;
    init_row.dr_hi = PORT_MAX;

    // Count and capacity of the list that an add in the input word aims at.
    case (in_op)
      OP_ADD_PROTO: begin
        sel_cnt = pcnt_r;
        sel_cap = PROTO_CAP;
      end
      OP_ADD_SRC_PF: begin
        sel_cnt = spcnt_r;
        sel_cap = PREFIX_CAP;
      end
      OP_ADD_DST_PF: begin
        sel_cnt = dpcnt_r;
        sel_cap = PREFIX_CAP;
      end
      OP_ADD_SRC_RG: begin
        sel_cnt = srcnt_r;
        sel_cap = RANGE_CAP;
      end
      OP_ADD_DST_RG: begin
        sel_cnt = drcnt_r;
        sel_cap = RANGE_CAP;
      end
      default: begin
        sel_cnt = '0;
        sel_cap = '0;
      end
    endcase

    span_a = (pcnt_r > spcnt_r) ? pcnt_r : spcnt_r;
    span_a = (span_a > dpcnt_r) ? span_a : dpcnt_r;
    span_b = (srcnt_r > drcnt_r) ? srcnt_r : drcnt_r;

    issue  = (iss_idx_r < span_r);

    wr_row = cur_row;
    case (op_r)
      OP_ADD_PROTO:  wr_row.proto = protocol_r;
      OP_ADD_SRC_PF: begin
        wr_row.sp_addr = rule_addr_r;
        wr_row.sp_mask = rule_mask_r;
      end
      OP_ADD_DST_PF: begin
        wr_row.dp_addr = rule_addr_r;
        wr_row.dp_mask = rule_mask_r;
      end
      OP_ADD_SRC_RG: begin
        wr_row.sr_lo = range_lo_r;
        wr_row.sr_hi = range_hi_r;
      end
      OP_ADD_DST_RG: begin
        wr_row.dr_lo = range_lo_r;
        wr_row.dr_hi = range_hi_r;
      end
      default: ;
    endcase

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ROW_AW'(init_idx_r);
        ram_wdata = init_row;
        if (init_idx_r == INIT_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          init_idx_nxt = 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          res_status_nxt  = 1'b0;
          res_matched_nxt = 1'b0;
          unique case (in_op) inside
            OP_MATCH: begin
              hp_nxt      = 1'b0;
              hsp_nxt     = 1'b0;
              hdp_nxt     = 1'b0;
              hsr_nxt     = 1'b0;
              hdr_nxt     = 1'b0;
              iss_idx_nxt = '0;
              span_nxt    = (span_a > span_b) ? span_a : span_b;
              state_nxt   = ST_MATCH;
            end
            OP_ADD_PROTO, OP_ADD_SRC_PF, OP_ADD_DST_PF, OP_ADD_SRC_RG, OP_ADD_DST_RG: begin
              if (sel_cnt >= sel_cap) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_EMIT;
              end else begin
                ram_re      = 1'b1;
                ram_raddr   = sel_cnt[ROW_AW-1:0];
                add_idx_nxt = sel_cnt[ROW_AW-1:0];
                state_nxt   = ST_ADD;
              end
            end
            OP_CLEAR: begin
              // Emptied lists need no memory pass: rows beyond a count are never tested.
              pcnt_nxt  = '0;
              spcnt_nxt = '0;
              dpcnt_nxt = '0;
              srcnt_nxt = '0;
              drcnt_nxt = '0;
              state_nxt = ST_EMIT;
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end

      ST_MATCH: begin
        // Test the row that arrived this cycle against every list whose count covers it.
        if (pend_r) begin
          hp_nxt  = hp_r  || ((pidx_r < pcnt_r) && (cur_row.proto == protocol_r));
          hsp_nxt = hsp_r || ((pidx_r < spcnt_r) &&
                              ((src_addr_r & cur_row.sp_mask) == cur_row.sp_addr));
          hdp_nxt = hdp_r || ((pidx_r < dpcnt_r) &&
                              ((dst_addr_r & cur_row.dp_mask) == cur_row.dp_addr));
          hsr_nxt = hsr_r || ((pidx_r < srcnt_r) && (src_port_r >= cur_row.sr_lo) &&
                              (src_port_r <= cur_row.sr_hi));
          hdr_nxt = hdr_r || ((pidx_r < drcnt_r) && (dst_port_r >= cur_row.dr_lo) &&
                              (dst_port_r <= cur_row.dr_hi));
        end
        if (issue) begin
          ram_re      = 1'b1;
          ram_raddr   = iss_idx_r[ROW_AW-1:0];
          pidx_nxt    = iss_idx_r;
          iss_idx_nxt = iss_idx_r + ONE;
          pend_nxt    = 1'b1;
        end else if (!pend_r) begin
          res_matched_nxt = hp_r && hsp_r && hdp_r && hsr_r && hdr_r;
          state_nxt       = ST_EMIT;
        end
      end

      ST_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = add_idx_r;
        ram_wdata = wr_row;
        case (op_r)
          OP_ADD_PROTO:  pcnt_nxt  = pcnt_r + ONE;
          OP_ADD_SRC_PF: spcnt_nxt = spcnt_r + ONE;
          OP_ADD_DST_PF: dpcnt_nxt = dpcnt_r + ONE;
          OP_ADD_SRC_RG: srcnt_nxt = srcnt_r + ONE;
          OP_ADD_DST_RG: drcnt_nxt = drcnt_r + ONE;
          default: ;
        endcase
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_idx_r  <= 1'b0;
      pcnt_r      <= PROTO_RST;
      spcnt_r     <= ONE;
      dpcnt_r     <= ONE;
      srcnt_r     <= ONE;
      drcnt_r     <= ONE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      conn_id_r   <= '0;
      prio_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      pcnt_r      <= pcnt_nxt;
      spcnt_r     <= spcnt_nxt;
      dpcnt_r     <= dpcnt_nxt;
      srcnt_r     <= srcnt_nxt;
      drcnt_r     <= drcnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CONNECTION_ID: conn_id_r <= cfg_wdata;
          CFG_RULE_PRIORITY: prio_r    <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    iss_idx_r     <= iss_idx_nxt;
    pidx_r        <= pidx_nxt;
    span_r        <= span_nxt;
    add_idx_r     <= add_idx_nxt;
    hp_r          <= hp_nxt;
    hsp_r         <= hsp_nxt;
    hdp_r         <= hdp_nxt;
    hsr_r         <= hsr_nxt;
    hdr_r         <= hdr_nxt;
    res_status_r  <= res_status_nxt;
    res_matched_r <= res_matched_nxt;
    if (in_acc) begin
      op_r        <= in_op;
      src_addr_r  <= in_tdata[31:0];
      dst_addr_r  <= in_tdata[63:32];
      src_port_r  <= in_tdata[79:64];
      dst_port_r  <= in_tdata[95:80];
      protocol_r  <= in_tdata[103:96];
      rule_addr_r <= in_tdata[135:104];
      rule_mask_r <= in_tdata[167:136];
      range_lo_r  <= in_tdata[183:168];
      range_hi_r  <= in_tdata[199:184];
    end
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_matched_r <= res_matched_r;
      out_conn_r    <= res_matched_r ? conn_id_r : 16'd0;
      out_prio_r    <= res_matched_r ? prio_r : 8'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_prio_r, out_conn_r, out_matched_r};
  assign out_tuser  = out_status_r;

  assign counts_ok = (pcnt_r <= PROTO_CAP) && (spcnt_r <= PREFIX_CAP) &&
                     (dpcnt_r <= PREFIX_CAP) && (srcnt_r <= RANGE_CAP) &&
                     (drcnt_r <= RANGE_CAP);

  // No list count ever grows beyond the depth of its list.
  `FTRM_ASSERT_IMP(a_count_bound, 1'b1, counts_ok)
  // A successful match never comes with a refusal status.
  `FTRM_ASSERT_IMP(a_match_status, out_tvalid && out_tdata[0], !out_tuser[0])
  // The rule memory is written only by the start-up fill and by an add.
  `FTRM_ASSERT_IMP(a_ram_write_src, ram_we, (state_r == ST_ADD) || (state_r == ST_INIT))
  // One word at a time: an accepted word closes the input until its result is loaded.
  `FTRM_ASSERT_NXT(a_one_in_flight, in_acc, !in_tready)

endmodule

>>> rtl/ftrm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ftrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
